@@ src/tpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Triple-prime modular ALU package
// Shared widths, prime constants, Barrett factors, operation codes and the
// control word that travels with each request through the modular multiplier.
// ----------------------------------------------------------------------------
package tpm_pkg;

    // Residue lanes, one for each prime.
    localparam int NUM_LANES = 3;
    localparam int RES_W     = 30;
    localparam int RAW_W     = 64;
    localparam int EXP_W     = 63;
    localparam int FUNC_W    = 3;

    // Barrett reduction widths: products stay below 2^(2*RES_W).
    localparam int PROD_W = 2 * RES_W;
    localparam int MU_W   = RES_W + 1;
    localparam int Q_W    = 2 * MU_W;
    localparam int REM_W  = RES_W + 2;

    localparam logic [RES_W-1:0] PRIME_A = 30'd1000000007;
    localparam logic [RES_W-1:0] PRIME_B = 30'd1000000009;
    localparam logic [RES_W-1:0] PRIME_C = 30'd1000000021;

    // Barrett factors floor(2^60 / p), worked out at elaboration.
    localparam logic [63:0] MU_A_FULL = (64'd1 << PROD_W) / {34'd0, PRIME_A};
    localparam logic [63:0] MU_B_FULL = (64'd1 << PROD_W) / {34'd0, PRIME_B};
    localparam logic [63:0] MU_C_FULL = (64'd1 << PROD_W) / {34'd0, PRIME_C};

    typedef logic [NUM_LANES-1:0][RES_W-1:0] t_res_vec;
    typedef logic [NUM_LANES-1:0][RES_W:0]   t_opb_vec;
    typedef logic [NUM_LANES-1:0][MU_W-1:0]  t_mu_vec;

    localparam t_res_vec PRIMES = {PRIME_C, PRIME_B, PRIME_A};
    localparam t_mu_vec  MUS    = {MU_C_FULL[MU_W-1:0], MU_B_FULL[MU_W-1:0],
                                   MU_A_FULL[MU_W-1:0]};

    // 2^30 as a multiplier operand, used to shift a partial remainder by one digit.
    localparam logic [RES_W:0] RADIX = {1'b1, {RES_W{1'b0}}};

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_REDUCE = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_MUL    = 3'd3,
        FN_DIV    = 3'd4,
        FN_POW    = 3'd5,
        FN_EQUAL  = 3'd6,
        FN_INV    = 3'd7
    } t_func;

    // Destination of a multiplier result inside a power round.
    typedef enum logic {
        TAG_ACC  = 1'b0,
        TAG_BASE = 1'b1
    } t_mm_tag;

    typedef struct packed {
        logic    vld;
        t_mm_tag tag;
    } t_mm_ctl;

endpackage

@@ src/triple_prime_modular_alu_top.sv @@
// ----------------------------------------------------------------------------
// Triple-prime modular ALU
// Residue-triple arithmetic modulo 1000000007, 1000000009 and 1000000021:
// reduce, add, subtract, multiply, divide, power, equality and inverse.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start, busy             i_func, i_x_res_*, i_y_res_*,
//                                              i_exponent, i_raw_*
// result    out        o_done (one-cycle)      o_res_a/b/c, o_is_equal
//
// An item is taken when start is high and busy is low; busy stays high until
// the result strobe. Add, subtract and equality finish in the sequencer;
// multiply and reduce use the five-stage modular multiplier, and power,
// inverse and divide run a square-and-multiply loop around it, up to the
// highest set exponent bit.
// Reset is synchronous and active low; the result side cannot stall.
// ----------------------------------------------------------------------------
module triple_prime_modular_alu_top
    import tpm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [RES_W-1:0]        i_x_res_a,
    input  logic [RES_W-1:0]        i_x_res_b,
    input  logic [RES_W-1:0]        i_x_res_c,
    input  logic [RES_W-1:0]        i_y_res_a,
    input  logic [RES_W-1:0]        i_y_res_b,
    input  logic [RES_W-1:0]        i_y_res_c,
    input  logic [EXP_W-1:0]        i_exponent,
    input  logic signed [RAW_W-1:0] i_raw_a,
    input  logic signed [RAW_W-1:0] i_raw_b,
    input  logic signed [RAW_W-1:0] i_raw_c,
    output logic                    o_done,
    output logic [RES_W-1:0]        o_res_a,
    output logic [RES_W-1:0]        o_res_b,
    output logic [RES_W-1:0]        o_res_c,
    output logic                    o_is_equal
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_EXEC,
        S_RED_W1,
        S_RED2,
        S_RED_W2,
        S_MUL_W,
        S_POW,
        S_SQ,
        S_POW_W
    } t_state;

    t_state   r_state;
    t_func    r_func;
    t_res_vec r_x;
    t_res_vec r_y;
    t_res_vec r_base;
    t_res_vec r_acc;
    t_res_vec r_res;
    logic     r_eq;
    logic     r_done;

    logic [NUM_LANES-1:0][RAW_W-1:0] r_mag;
    logic [NUM_LANES-1:0]            r_neg;
    logic [NUM_LANES-1:0][EXP_W-1:0] r_exp;

    logic [NUM_LANES-1:0][RAW_W-1:0] raw_in;
    t_res_vec                        x_in;
    t_res_vec                        y_in;
    logic                            accept;
    logic                            exp_zero;

    t_mm_ctl  mm_ctl;
    t_res_vec mm_a;
    t_opb_vec mm_b;
    t_res_vec mm_c;
    t_mm_ctl  mm_out_ctl;
    t_res_vec mm_res;

    assign raw_in = {i_raw_c, i_raw_b, i_raw_a};
    assign x_in   = {i_x_res_c, i_x_res_b, i_x_res_a};
    assign y_in   = {i_y_res_c, i_y_res_b, i_y_res_a};
    assign accept = start && (r_state == S_IDLE);
    assign exp_zero = (r_exp == '0);

    // Request to the shared multiplier, chosen by the sequencer state.
    always_comb begin
        mm_ctl = '{vld: 1'b0, tag: TAG_ACC};
        mm_a   = r_acc;
        mm_b   = '0;
        mm_c   = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            mm_b[l] = {1'b0, r_base[l]};
        end
        case (r_state)
            S_EXEC: begin
                if (r_func == FN_MUL) begin
                    mm_ctl.vld = 1'b1;
                    mm_a       = r_x;
                    for (int l = 0; l < NUM_LANES; l++) begin
                        mm_b[l] = {1'b0, r_y[l]};
                    end
                end else if (r_func == FN_REDUCE) begin
                    // Top digit of the magnitude, shifted up by one digit, plus the middle digit.
                    mm_ctl.vld = 1'b1;
                    for (int l = 0; l < NUM_LANES; l++) begin
                        mm_a[l] = RES_W'(r_mag[l][RAW_W-1:PROD_W]);
                        mm_b[l] = RADIX;
                        mm_c[l] = r_mag[l][PROD_W-1:RES_W];
                    end
                end
            end
            S_RED2: begin
                mm_ctl.vld = 1'b1;
                for (int l = 0; l < NUM_LANES; l++) begin
                    mm_b[l] = RADIX;
                    mm_c[l] = r_mag[l][RES_W-1:0];
                end
            end
            S_POW: begin
                // Either the next accumulator product, or the final divide product.
                mm_ctl.vld = 1'b1;
                if (exp_zero) begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        mm_b[l] = {1'b0, r_x[l]};
                    end
                    mm_ctl.vld = (r_func == FN_DIV);
                end
            end
            S_SQ: begin
                mm_ctl = '{vld: 1'b1, tag: TAG_BASE};
                mm_a   = r_base;
            end
            default: begin
                mm_ctl.vld = 1'b0;
            end
        endcase
    end

    tpm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mm_ctl),
        .i_op_a  (mm_a),
        .i_op_b  (mm_b),
        .i_op_c  (mm_c),
        .o_ctl   (mm_out_ctl),
        .o_res   (mm_res)
    );

    // Sequencer with its operand and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_func)
                        FN_REDUCE: r_state <= S_RED_W1;
                        FN_MUL:    r_state <= S_MUL_W;
                        FN_DIV, FN_POW, FN_INV: begin
                            r_state <= S_POW;
                        end
                        default: begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    endcase
                end
                S_RED_W1: begin
                    if (mm_out_ctl.vld) begin
                        r_state <= S_RED2;
                    end
                end
                S_RED2: begin
                    r_state <= S_RED_W2;
                end
                S_RED_W2, S_MUL_W: begin
                    if (mm_out_ctl.vld) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_POW: begin
                    if (!exp_zero) begin
                        r_state <= S_SQ;
                    end else if (r_func == FN_DIV) begin
                        r_state <= S_MUL_W;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_SQ: begin
                    r_state <= S_POW_W;
                end
                S_POW_W: begin
                    if (mm_out_ctl.vld && mm_out_ctl.tag == TAG_BASE) begin
                        r_state <= S_POW;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // Datapath registers need no reset.
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_func <= t_func'(i_func);
                    r_x    <= x_in;
                    r_y    <= y_in;
                    for (int l = 0; l < NUM_LANES; l++) begin
                        r_neg[l] <= raw_in[l][RAW_W-1];
                        r_mag[l] <= raw_in[l][RAW_W-1] ? (~raw_in[l] + RAW_W'(1))
                                                       : raw_in[l];
                        if (t_func'(i_func) == FN_POW) begin
                            r_exp[l] <= i_exponent;
                        end else begin
                            r_exp[l] <= EXP_W'(PRIMES[l]) - EXP_W'(2);
                        end
                    end
                end
            end
            S_PREP: begin
                // Inputs may sit one prime above their range.
                for (int l = 0; l < NUM_LANES; l++) begin
                    if (r_x[l] >= PRIMES[l]) begin
                        r_x[l] <= r_x[l] - PRIMES[l];
                    end
                    if (r_y[l] >= PRIMES[l]) begin
                        r_y[l] <= r_y[l] - PRIMES[l];
                    end
                end
            end
            S_EXEC: begin
                r_eq <= (r_func == FN_EQUAL) && (r_x == r_y);
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_acc[l]  <= RES_W'(1);
                    r_base[l] <= (r_func == FN_POW) ? r_x[l] : r_y[l];
                    case (r_func)
                        FN_ADD: begin
                            if ((RES_W+1)'(r_x[l]) + (RES_W+1)'(r_y[l])
                                    >= (RES_W+1)'(PRIMES[l])) begin
                                r_res[l] <= r_x[l] + r_y[l] - PRIMES[l];
                            end else begin
                                r_res[l] <= r_x[l] + r_y[l];
                            end
                        end
                        FN_SUB: begin
                            if (r_x[l] >= r_y[l]) begin
                                r_res[l] <= r_x[l] - r_y[l];
                            end else begin
                                r_res[l] <= r_x[l] + PRIMES[l] - r_y[l];
                            end
                        end
                        default: begin
                            r_res[l] <= '0;
                        end
                    endcase
                end
            end
            S_RED_W1: begin
                if (mm_out_ctl.vld) begin
                    r_acc <= mm_res;
                end
            end
            S_RED_W2: begin
                // Negative values map to p minus the magnitude's residue, or to zero when that residue is zero.
                if (mm_out_ctl.vld) begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        if (r_neg[l] && mm_res[l] != '0) begin
                            r_res[l] <= PRIMES[l] - mm_res[l];
                        end else begin
                            r_res[l] <= mm_res[l];
                        end
                    end
                end
            end
            S_MUL_W: begin
                if (mm_out_ctl.vld) begin
                    r_res <= mm_res;
                end
            end
            S_POW: begin
                if (exp_zero) begin
                    r_res <= r_acc;
                end
            end
            S_POW_W: begin
                // Accumulator product lands first, the square in the cycle after it.
                if (mm_out_ctl.vld) begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        if (mm_out_ctl.tag == TAG_ACC) begin
                            if (r_exp[l][0]) begin
                                r_acc[l] <= mm_res[l];
                            end
                        end else begin
                            r_base[l] <= mm_res[l];
                            r_exp[l]  <= r_exp[l] >> 1;
                        end
                    end
                end
            end
            default: begin
                r_eq <= r_eq;
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_res_a    = r_res[0];
    assign o_res_b    = r_res[1];
    assign o_res_c    = r_res[2];
    assign o_is_equal = r_eq;

endmodule

@@ src/tpm_modmul.sv @@
// ----------------------------------------------------------------------------
// Pipelined modular multiply-add
// Computes (a * b + c) mod p for all three primes at once, with a Barrett
// reduction spread over five register stages. The sum a * b + c must stay
// below 2^60. A new request may enter in every cycle.
// ----------------------------------------------------------------------------
module tpm_modmul
    import tpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mm_ctl  i_ctl,
    input  t_res_vec i_op_a,
    input  t_opb_vec i_op_b,
    input  t_res_vec i_op_c,
    output t_mm_ctl  o_ctl,
    output t_res_vec o_res
);

    localparam int STAGES = 5;

    t_mm_ctl r_ctl [STAGES];

    logic [NUM_LANES-1:0][PROD_W-1:0] r_prod;
    logic [NUM_LANES-1:0][Q_W-1:0]    r_q2;
    logic [NUM_LANES-1:0][REM_W-1:0]  r_low2;
    logic [NUM_LANES-1:0][REM_W-1:0]  r_low3;
    logic [NUM_LANES-1:0][REM_W-1:0]  r_qp;
    logic [NUM_LANES-1:0][REM_W-1:0]  r_rem;
    t_res_vec                         r_res;

    logic [NUM_LANES-1:0][PROD_W:0]        n_full;
    logic [NUM_LANES-1:0][Q_W-1:0]         n_q2;
    logic [NUM_LANES-1:0][MU_W+RES_W-1:0]  n_qpf;
    logic [NUM_LANES-1:0][REM_W-1:0]       n_rem;
    logic [NUM_LANES-1:0][REM_W:0]         n_d1;
    logic [NUM_LANES-1:0][REM_W:0]         n_d2;
    t_res_vec                              n_res;

    // Lane arithmetic: product, two Barrett multiplies, remainder, final correction.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_full[l] = (PROD_W+1)'(i_op_a[l]) * (PROD_W+1)'(i_op_b[l])
                      + (PROD_W+1)'(i_op_c[l]);
            n_q2[l]   = Q_W'(r_prod[l][PROD_W-1:RES_W-1]) * Q_W'(MUS[l]);
            n_qpf[l]  = (MU_W+RES_W)'(r_q2[l][Q_W-1:MU_W]) * (MU_W+RES_W)'(PRIMES[l]);
            n_rem[l]  = r_low3[l] - r_qp[l];
            // The remainder lies below 3p: subtract p or 2p where it fits.
            n_d1[l]   = {1'b0, r_rem[l]} - {3'b000, PRIMES[l]};
            n_d2[l]   = {1'b0, r_rem[l]} - {2'b00, PRIMES[l], 1'b0};
            if (!n_d2[l][REM_W]) begin
                n_res[l] = n_d2[l][RES_W-1:0];
            end else if (!n_d1[l][REM_W]) begin
                n_res[l] = n_d1[l][RES_W-1:0];
            end else begin
                n_res[l] = r_rem[l][RES_W-1:0];
            end
        end
    end

    // Control travels alongside the data and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < STAGES; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Data stages.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            r_prod[l] <= n_full[l][PROD_W-1:0];
            r_q2[l]   <= n_q2[l];
            r_low2[l] <= r_prod[l][REM_W-1:0];
            r_qp[l]   <= n_qpf[l][REM_W-1:0];
            r_low3[l] <= r_low2[l];
            r_rem[l]  <= n_rem[l];
            r_res[l]  <= n_res[l];
        end
    end

    assign o_ctl = r_ctl[STAGES-1];
    assign o_res = r_res;

endmodule

@@ src/tpm_checker.sv @@
// ----------------------------------------------------------------------------
// Triple-prime modular ALU port checker
// Watches the top-level ports for handshake and strobe timing and result ranges.
// ----------------------------------------------------------------------------
module tpm_checker
    import tpm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_done,
    input logic [RES_W-1:0]        o_res_a,
    input logic [RES_W-1:0]        o_res_b,
    input logic [RES_W-1:0]        o_res_c,
    input logic                    o_is_equal
);

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result strobe closes a busy period.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // Each item gives exactly one strobe cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // Residues are fully reduced at every result strobe.
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res_a < PRIME_A && o_res_b < PRIME_B && o_res_c < PRIME_C))
        else $error("result residue not reduced");

    // The equality test reports zero residues.
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_equal) |-> (o_res_a == '0 && o_res_b == '0 && o_res_c == '0))
        else $error("equal flag with nonzero residues");

endmodule

bind triple_prime_modular_alu_top tpm_checker u_tpm_checker (.*);

@@ dv/triple_prime_modular_alu_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triple-prime modular ALU result checker
// Watches the command and result channels of the ALU, works out the residue
// triple and equal flag that each accepted item must produce, and compares
// every result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module triple_prime_modular_alu_checker
    import tpm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [RES_W-1:0]        i_x_res_a,
    input  logic [RES_W-1:0]        i_x_res_b,
    input  logic [RES_W-1:0]        i_x_res_c,
    input  logic [RES_W-1:0]        i_y_res_a,
    input  logic [RES_W-1:0]        i_y_res_b,
    input  logic [RES_W-1:0]        i_y_res_c,
    input  logic [EXP_W-1:0]        i_exponent,
    input  logic [RAW_W-1:0]        i_raw_a,
    input  logic [RAW_W-1:0]        i_raw_b,
    input  logic [RAW_W-1:0]        i_raw_c,
    input  logic                    i_done,
    input  logic [RES_W-1:0]        i_res_a,
    input  logic [RES_W-1:0]        i_res_b,
    input  logic [RES_W-1:0]        i_res_c,
    input  logic                    i_is_equal,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [RES_W-1:0] res_a;
        logic [RES_W-1:0] res_b;
        logic [RES_W-1:0] res_c;
        logic             is_equal;
    } t_alu_result;

    t_alu_result alu_results_due[$];
    t_alu_result observed;
    t_alu_result predicted;

    // Product of two residues; both are below 2^30, so 64 bits never overflow.
    function automatic logic [63:0] lane_mul(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] m);
        return (a * b) % m;
    endfunction

    // Square-and-multiply over every exponent bit; a zero exponent yields one.
    function automatic logic [63:0] lane_pow(input logic [63:0] base, input logic [63:0] e,
                                             input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = base % m;
        for (int k = 0; k < 64; k++) begin
            if (e[k]) begin
                acc = lane_mul(acc, sq, m);
            end
            sq = lane_mul(sq, sq, m);
        end
        return acc;
    endfunction

    // Least non-negative residue of a two's complement value.
    function automatic logic [63:0] lane_reduce_signed(input logic [63:0] bits,
                                                       input logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] rem;
        if (!bits[63]) begin
            return bits % m;
        end
        mag = 64'd0 - bits;
        rem = mag % m;
        return (rem != 64'd0) ? m - rem : 64'd0;
    endfunction

    // Expected result of one item. Inverses follow Fermat, so zero maps to zero.
    function automatic t_alu_result alu_expected(input t_func f, input t_res_vec x,
                                                 input t_res_vec y,
                                                 input logic [EXP_W-1:0] e,
                                                 input logic [2:0][RAW_W-1:0] raw);
        t_alu_result r;
        logic [63:0] m;
        logic [63:0] xv;
        logic [63:0] yv;
        logic [63:0] lane;
        logic        eq;
        r  = '0;
        eq = 1'b1;
        for (int k = 0; k < NUM_LANES; k++) begin
            m  = {34'd0, PRIMES[k]};
            xv = {34'd0, x[k]} % m;
            yv = {34'd0, y[k]} % m;
            if (xv != yv) begin
                eq = 1'b0;
            end
            case (f)
                FN_REDUCE: lane = lane_reduce_signed(raw[k], m);
                FN_ADD:    lane = (xv + yv) % m;
                FN_SUB:    lane = (xv + m - yv) % m;
                FN_MUL:    lane = lane_mul(xv, yv, m);
                FN_DIV:    lane = lane_mul(xv, lane_pow(yv, m - 64'd2, m), m);
                FN_POW:    lane = lane_pow(xv, {1'b0, e}, m);
                FN_EQUAL:  lane = 64'd0;
                default:   lane = lane_pow(yv, m - 64'd2, m);
            endcase
            case (k)
                0:       r.res_a = lane[RES_W-1:0];
                1:       r.res_b = lane[RES_W-1:0];
                default: r.res_c = lane[RES_W-1:0];
            endcase
        end
        r.is_equal = (f == FN_EQUAL) && eq;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [RES_W-1:0] want,
                                 input logic [RES_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Results are checked before new items are queued, since a result and the
    // next item can share one clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_done) begin
                observed = '{i_res_a, i_res_b, i_res_c, i_is_equal};
                if (alu_results_due.size() == 0) begin
                    $display("%0t: result with no item outstanding: %0d %0d %0d eq %0b",
                             $time, i_res_a, i_res_b, i_res_c, i_is_equal);
                    o_fail_count++;
                end else begin
                    predicted = alu_results_due.pop_front();
                    compare_field("res_a", predicted.res_a, observed.res_a);
                    compare_field("res_b", predicted.res_b, observed.res_b);
                    compare_field("res_c", predicted.res_c, observed.res_c);
                    compare_field("is_equal", RES_W'(predicted.is_equal),
                                  RES_W'(observed.is_equal));
                end
            end
            if (i_start && !i_busy) begin
                alu_results_due.push_back(alu_expected(t_func'(i_func),
                    {i_x_res_c, i_x_res_b, i_x_res_a}, {i_y_res_c, i_y_res_b, i_y_res_a},
                    i_exponent, {i_raw_c, i_raw_b, i_raw_a}));
            end
            o_pending = alu_results_due.size();
        end
    end

endmodule

@@ dv/triple_prime_modular_alu_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triple-prime modular ALU testbench
// Drives directed corner items and then random items through the command
// channel with random sender gaps, and lets the checker beside the ALU judge
// every result strobe.
// ----------------------------------------------------------------------------
module triple_prime_modular_alu_top_tb;
    import tpm_pkg::*;

    localparam int          RANDOM_ITEMS = 1900;
    localparam int          QUIET_ITEMS  = 200;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam longint      TIMEOUT_NS   = 64'd50_000_000;

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
    localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
    localparam logic [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
    localparam logic [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
    localparam logic [RAW_W-1:0] RAW_NEG1 = {RAW_W{1'b1}};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [FUNC_W-1:0]       i_func;
    logic [RES_W-1:0]        i_x_res_a;
    logic [RES_W-1:0]        i_x_res_b;
    logic [RES_W-1:0]        i_x_res_c;
    logic [RES_W-1:0]        i_y_res_a;
    logic [RES_W-1:0]        i_y_res_b;
    logic [RES_W-1:0]        i_y_res_c;
    logic [EXP_W-1:0]        i_exponent;
    logic signed [RAW_W-1:0] i_raw_a;
    logic signed [RAW_W-1:0] i_raw_b;
    logic signed [RAW_W-1:0] i_raw_c;
    logic                    o_done;
    logic [RES_W-1:0]        o_res_a;
    logic [RES_W-1:0]        o_res_b;
    logic [RES_W-1:0]        o_res_c;
    logic                    o_is_equal;

    int fail_count;
    int pending;
    bit idle_enable;

    triple_prime_modular_alu_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_x_res_a  (i_x_res_a),
        .i_x_res_b  (i_x_res_b),
        .i_x_res_c  (i_x_res_c),
        .i_y_res_a  (i_y_res_a),
        .i_y_res_b  (i_y_res_b),
        .i_y_res_c  (i_y_res_c),
        .i_exponent (i_exponent),
        .i_raw_a    (i_raw_a),
        .i_raw_b    (i_raw_b),
        .i_raw_c    (i_raw_c),
        .o_done     (o_done),
        .o_res_a    (o_res_a),
        .o_res_b    (o_res_b),
        .o_res_c    (o_res_c),
        .o_is_equal (o_is_equal)
    );

    triple_prime_modular_alu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (i_func),
        .i_x_res_a    (i_x_res_a),
        .i_x_res_b    (i_x_res_b),
        .i_x_res_c    (i_x_res_c),
        .i_y_res_a    (i_y_res_a),
        .i_y_res_b    (i_y_res_b),
        .i_y_res_c    (i_y_res_c),
        .i_exponent   (i_exponent),
        .i_raw_a      (i_raw_a),
        .i_raw_b      (i_raw_b),
        .i_raw_c      (i_raw_c),
        .i_done       (o_done),
        .i_res_a      (o_res_a),
        .i_res_b      (o_res_b),
        .i_res_c      (o_res_c),
        .i_is_equal   (o_is_equal),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Residue with a bias toward zero, one, p-1 and unreduced values.
    function automatic logic [RES_W-1:0] rand_residue(input logic [RES_W-1:0] p);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 30'd1;
            2:       return p - 30'd1;
            3:       return p + RES_W'($urandom_range(0, int'(RES_MAX - p)));
            4:       return RES_MAX;
            default: return RES_W'($urandom_range(0, int'(p) - 1));
        endcase
    endfunction

    // A value congruent to x modulo p, sometimes in unreduced form.
    function automatic logic [RES_W-1:0] twin_residue(input logic [RES_W-1:0] x,
                                                      input logic [RES_W-1:0] p);
        if (x >= p) begin
            return x - p;
        end
        if ({1'b0, x} + {1'b0, p} <= {1'b0, RES_MAX} && $urandom_range(0, 1) == 1) begin
            return x + p;
        end
        return x;
    endfunction

    // Signed raw value: the extremes, small values of either sign, negative
    // multiples of the prime, or anything.
    function automatic logic [RAW_W-1:0] rand_raw(input logic [RES_W-1:0] p);
        longint tmp;
        case ($urandom_range(0, 7))
            0: return RAW_MIN;
            1: return RAW_MAX;
            2: return RAW_NEG1;
            3: begin
                tmp = longint'($urandom_range(0, 2000)) - 64'sd1000;
                return tmp;
            end
            4: return 64'd0 - 64'(p) * 64'($urandom_range(1, 1000));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Power exponents stay mostly short; full-width ones are the slow case.
    function automatic logic [EXP_W-1:0] rand_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return EXP_W'($urandom_range(1, 63));
            2:       return EXP_MAX;
            3, 4:    return EXP_W'({$urandom(), $urandom()});
            default: return EXP_W'($urandom() & 32'h000F_FFFF);
        endcase
    endfunction

    // Presents one item and returns at the edge that accepts it, then maybe
    // leaves the command channel idle for a random burst.
    task automatic issue_item(input t_func f,
                              input logic [RES_W-1:0] xa, input logic [RES_W-1:0] xb,
                              input logic [RES_W-1:0] xc, input logic [RES_W-1:0] ya,
                              input logic [RES_W-1:0] yb, input logic [RES_W-1:0] yc,
                              input logic [EXP_W-1:0] e, input logic [RAW_W-1:0] ra,
                              input logic [RAW_W-1:0] rb, input logic [RAW_W-1:0] rc);
        start      <= 1'b1;
        i_func     <= f;
        i_x_res_a  <= xa;
        i_x_res_b  <= xb;
        i_x_res_c  <= xc;
        i_y_res_a  <= ya;
        i_y_res_b  <= yb;
        i_y_res_c  <= yc;
        i_exponent <= e;
        i_raw_a    <= ra;
        i_raw_b    <= rb;
        i_raw_c    <= rc;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Safety net against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("[triple_prime_modular_alu_top] ERROR");
        $finish;
    end

    initial begin
        t_func            f;
        logic [RES_W-1:0] xa;
        logic [RES_W-1:0] xb;
        logic [RES_W-1:0] xc;
        logic [RES_W-1:0] ya;
        logic [RES_W-1:0] yb;
        logic [RES_W-1:0] yc;
        int               guard;

        idle_enable = 1'b1;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_func     <= FN_REDUCE;
        i_x_res_a  <= '0;
        i_x_res_b  <= '0;
        i_x_res_c  <= '0;
        i_y_res_a  <= '0;
        i_y_res_b  <= '0;
        i_y_res_c  <= '0;
        i_exponent <= '0;
        i_raw_a    <= '0;
        i_raw_b    <= '0;
        i_raw_c    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reduce: signed extremes, minus one, exact negative and positive multiples.
        issue_item(FN_REDUCE, '0, '0, '0, '0, '0, '0, '0, RAW_MIN, RAW_MAX, RAW_NEG1);
        issue_item(FN_REDUCE, '0, '0, '0, '0, '0, '0, '0, '0, 64'd0 - 64'(PRIME_B),
                   64'(PRIME_C) * 64'd3);
        // Add and subtract at the wrap points, with unreduced operands.
        issue_item(FN_ADD, PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1,
                   PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1, '0, '0, '0, '0);
        issue_item(FN_ADD, RES_MAX, RES_MAX, RES_MAX, '0, 30'd1, PRIME_C, '0, '0, '0, '0);
        issue_item(FN_SUB, '0, '0, '0, PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1,
                   '0, '0, '0, '0);
        issue_item(FN_SUB, PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1,
                   RES_MAX, RES_MAX, RES_MAX, '0, '0, '0, '0);
        // Multiply at the largest residues.
        issue_item(FN_MUL, PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1,
                   PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1, '0, '0, '0, '0);
        issue_item(FN_MUL, RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX, RES_MAX,
                   '0, '0, '0, '0);
        // Divide by zero, in full and per lane, and an ordinary divide.
        issue_item(FN_DIV, 30'd5, 30'd6, 30'd7, '0, '0, '0, '0, '0, '0, '0);
        issue_item(FN_DIV, 30'd123456789, RES_MAX, 30'd42, '0, PRIME_B, 30'd3,
                   '0, '0, '0, '0);
        issue_item(FN_DIV, 30'd1, 30'd1, 30'd1, PRIME_A - 30'd1, PRIME_B - 30'd1,
                   PRIME_C - 30'd1, '0, '0, '0, '0);
        // Power: zero exponent on a zero base, the widest exponent, exponent one, exponent p-1.
        issue_item(FN_POW, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        issue_item(FN_POW, RES_MAX, RES_MAX, RES_MAX, '0, '0, '0, EXP_MAX, '0, '0, '0);
        issue_item(FN_POW, PRIME_A - 30'd1, PRIME_B - 30'd1, PRIME_C - 30'd1,
                   '0, '0, '0, 63'd1, '0, '0, '0);
        issue_item(FN_POW, 30'd2, PRIME_B, 30'd3, '0, '0, '0, 63'(PRIME_A - 30'd1),
                   '0, '0, '0);
        // Equality: identical, equal only after reduction, one lane apart.
        issue_item(FN_EQUAL, 30'd12345, 30'd678, 30'd9, 30'd12345, 30'd678, 30'd9,
                   '0, '0, '0, '0);
        issue_item(FN_EQUAL, PRIME_A, PRIME_B + 30'd7, PRIME_C + 30'd3, '0, 30'd7, 30'd3,
                   '0, '0, '0, '0);
        issue_item(FN_EQUAL, 30'd11, 30'd22, 30'd33, 30'd11, 30'd22, 30'd34,
                   '0, '0, '0, '0);
        // Inverse of zero, one, p-1 and unreduced values.
        issue_item(FN_INV, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        issue_item(FN_INV, '0, '0, '0, 30'd1, PRIME_B - 30'd1, RES_MAX, '0, '0, '0, '0);
        issue_item(FN_INV, RES_MAX, RES_MAX, RES_MAX, 30'd2, 30'd3, PRIME_C,
                   '0, '0, '0, '0);

        // Random items; the tail runs back to back.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_enable = (n < RANDOM_ITEMS - QUIET_ITEMS);
            f  = t_func'($urandom_range(0, 7));
            xa = rand_residue(PRIME_A);
            xb = rand_residue(PRIME_B);
            xc = rand_residue(PRIME_C);
            ya = rand_residue(PRIME_A);
            yb = rand_residue(PRIME_B);
            yc = rand_residue(PRIME_C);
            // Half of the equality items compare congruent operands.
            if (f == FN_EQUAL && $urandom_range(0, 1) == 1) begin
                ya = twin_residue(xa, PRIME_A);
                yb = twin_residue(xb, PRIME_B);
                yc = twin_residue(xc, PRIME_C);
            end
            issue_item(f, xa, xb, xc, ya, yb, yc, rand_exponent(), rand_raw(PRIME_A),
                       rand_raw(PRIME_B), rand_raw(PRIME_C));
        end
        start <= 1'b0;

        // Drain outstanding results, then watch a little longer for strays.
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (16) @(negedge i_clk);
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("[triple_prime_modular_alu_top] OK");
        end else begin
            $display("[triple_prime_modular_alu_top] ERROR");
        end
        $finish;
    end

endmodule
